// ===== rtl/adiv64_pkg.sv =====
package adiv64_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned HALF_W  = DATA_W / 2;
  // Shift amount 0..HALF_W
  localparam int unsigned SHIFT_W = $clog2(HALF_W + 1);

  localparam int unsigned BITS_PER_STAGE_DEF = 4;

  typedef struct packed {
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } adiv_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    logic              div_by_zero;
  } adiv_out_t;

endpackage

// ===== rtl/approx_div64_by_64_core.sv =====
// Approximate unsigned 64-by-64 divider. It takes one beat per clock whenever
// start is high; busy is always low. The result of each beat appears on
// out_data for exactly one cycle, marked by out_valid, after the beat has
// passed the stage-1, stage-2 and division stage registers in turn. Results
// come out in the order the beats went in, and the receiver must take each
// one in the cycle that it appears. The first two stages find the highest set
// bit of the divisor's upper half and shift both operands right by that
// amount. The rest is a restoring divider of the 64-bit dividend by the
// remaining 32-bit divisor, unrolled across 64/BITS_PER_STAGE register
// stages with BITS_PER_STAGE (four by default) subtract-compare steps each;
// that per-stage chain sets the clock. A zero divisor gives an all-ones
// quotient with div_by_zero set.
module approx_div64_by_64_core #(
  parameter int unsigned BITS_PER_STAGE = adiv64_pkg::BITS_PER_STAGE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  adiv64_pkg::adiv_in_t  in_data,
  output logic                  out_valid,
  output adiv64_pkg::adiv_out_t out_data
);

  localparam int unsigned DATA_W     = adiv64_pkg::DATA_W;
  localparam int unsigned HALF_W     = adiv64_pkg::HALF_W;
  localparam int unsigned SHIFT_W    = adiv64_pkg::SHIFT_W;
  localparam int unsigned NUM_STAGES = DATA_W / BITS_PER_STAGE;
  localparam int unsigned LATENCY    = NUM_STAGES + 2;

  typedef struct packed {
    logic              dz;
    logic [HALF_W-1:0] d;
    logic [HALF_W-1:0] rem;
    // Remaining dividend bits on top, quotient bits shifted in below
    logic [DATA_W-1:0] nq;
  } div_stage_t;

  assign busy = 1'b0;

  // ---------------- stage 1: find last set in divisor upper half
  logic [HALF_W-1:0]  fls_v;
  logic [SHIFT_W-1:0] fls_pos;

  always_comb begin
    fls_v   = in_data.divisor[DATA_W-1:HALF_W];
    fls_pos = SHIFT_W'(HALF_W);
    if (fls_v == '0) begin
      fls_pos = '0;
    end else begin
      if ((fls_v & 32'hffff0000) == '0) begin
        fls_v   = fls_v << 16;
        fls_pos = fls_pos - SHIFT_W'(16);
      end
      if ((fls_v & 32'hff000000) == '0) begin
        fls_v   = fls_v << 8;
        fls_pos = fls_pos - SHIFT_W'(8);
      end
      if ((fls_v & 32'hf0000000) == '0) begin
        fls_v   = fls_v << 4;
        fls_pos = fls_pos - SHIFT_W'(4);
      end
      if ((fls_v & 32'hc0000000) == '0) begin
        fls_v   = fls_v << 2;
        fls_pos = fls_pos - SHIFT_W'(2);
      end
      if ((fls_v & 32'h80000000) == '0) begin
        fls_pos = fls_pos - SHIFT_W'(1);
      end
    end
  end

  logic               s1_valid_r;
  logic [DATA_W-1:0]  s1_num_r;
  logic [DATA_W-1:0]  s1_den_r;
  logic [SHIFT_W-1:0] s1_shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_num_r   <= in_data.dividend;
    s1_den_r   <= in_data.divisor;
    s1_shift_r <= fls_pos;
  end

  // ---------------- stage 2: normalize operands
  logic [DATA_W-1:0] num_sh;
  logic [DATA_W-1:0] den_sh;
  logic              s2_valid_r;
  div_stage_t        s2_r;
  div_stage_t        s2_nxt;

  always_comb begin
    num_sh     = s1_num_r >> s1_shift_r;
    den_sh     = s1_den_r >> s1_shift_r;
    s2_nxt.d   = den_sh[HALF_W-1:0];
    s2_nxt.dz  = (den_sh[HALF_W-1:0] == '0);
    s2_nxt.rem = '0;
    s2_nxt.nq  = num_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
  end

  // ---------------- restoring division stages
  logic       dv_valid_r [NUM_STAGES];
  div_stage_t dv_r       [NUM_STAGES];
  div_stage_t dv_nxt     [NUM_STAGES];

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_div
    div_stage_t src;
    logic       src_valid;

    if (g == 0) begin : g_first
      assign src       = s2_r;
      assign src_valid = s2_valid_r;
    end else begin : g_next
      assign src       = dv_r[g-1];
      assign src_valid = dv_valid_r[g-1];
    end

    always_comb begin
      div_stage_t        cur;
      logic [HALF_W:0]   trial;
      logic [HALF_W:0]   diff;
      logic              qbit;
      cur = src;
      for (int k = 0; k < BITS_PER_STAGE; k++) begin
        trial = {cur.rem, cur.nq[DATA_W-1]};
        diff  = trial - {1'b0, cur.d};
        qbit  = (trial >= {1'b0, cur.d});
        // Keep the difference only when the divisor fits
        cur.rem = qbit ? diff[HALF_W-1:0] : trial[HALF_W-1:0];
        cur.nq  = {cur.nq[DATA_W-2:0], qbit};
      end
      dv_nxt[g] = cur;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[g] <= 1'b0;
      end else begin
        dv_valid_r[g] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      dv_r[g] <= dv_nxt[g];
    end
  end

  // ---------------- result
  assign out_valid            = dv_valid_r[NUM_STAGES-1];
  assign out_data.div_by_zero = dv_r[NUM_STAGES-1].dz;
  assign out_data.quotient    = dv_r[NUM_STAGES-1].dz ? '1 : dv_r[NUM_STAGES-1].nq;

`ifndef SYNTHESIS
  a_one_result_per_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted beat produced no result strobe");

  a_zero_divisor_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.divisor == '0) |-> ##LATENCY
      (out_valid && out_data.div_by_zero))
    else $error("zero divisor not flagged");

  a_nonzero_divisor_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.divisor != '0) |-> ##LATENCY
      (out_valid && !out_data.div_by_zero))
    else $error("nonzero divisor flagged as zero");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_valid_r[NUM_STAGES-1] && !dv_r[NUM_STAGES-1].dz) |->
      (dv_r[NUM_STAGES-1].rem < dv_r[NUM_STAGES-1].d))
    else $error("final remainder not below divisor");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned RANDOM_BEATS = 1800;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  class quotient_tracker;
    adiv64_pkg::adiv_out_t expected_q[$];
    int unsigned           mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Shift both operands by the top set bit of the divisor's upper half.
    function adiv64_pkg::adiv_out_t approx_quotient(adiv64_pkg::adiv_in_t beat);
      logic [31:0]           hi;
      logic [63:0]           num;
      logic [63:0]           den;
      logic [31:0]           d32;
      int unsigned           sh;
      int                    i;
      adiv64_pkg::adiv_out_t res;
      hi = beat.divisor[63:32];
      sh = 0;
      for (i = 0; i < 32; i++) begin
        if (hi[i]) sh = i + 1;
      end
      num = beat.dividend >> sh;
      den = beat.divisor >> sh;
      d32 = den[31:0];
      if (d32 == 32'd0) begin
        res.quotient    = '1;
        res.div_by_zero = 1'b1;
      end else begin
        res.quotient    = num / {32'd0, d32};
        res.div_by_zero = 1'b0;
      end
      return res;
    endfunction

    function void note_beat(adiv64_pkg::adiv_in_t beat);
      expected_q.push_back(approx_quotient(beat));
    endfunction

    function void check_result(adiv64_pkg::adiv_out_t got);
      adiv64_pkg::adiv_out_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual quotient %h div_by_zero %b",
                 $time, got.quotient, got.div_by_zero);
        mismatch_count++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.quotient !== exp_res.quotient) begin
        $display("%0t: quotient mismatch, expected %h actual %h",
                 $time, exp_res.quotient, got.quotient);
        mismatch_count++;
      end
      if (got.div_by_zero !== exp_res.div_by_zero) begin
        $display("%0t: div_by_zero mismatch, expected %b actual %b",
                 $time, exp_res.div_by_zero, got.div_by_zero);
        mismatch_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  adiv64_pkg::adiv_in_t  in_data = '0;
  logic                  out_valid;
  adiv64_pkg::adiv_out_t out_data;

  quotient_tracker tracker = new();
  int unsigned     cycle_count = 0;
  logic            no_idle = 1'b0;

  approx_div64_by_64_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && start && !busy) tracker.note_beat(in_data);
    if (rst_n && out_valid) tracker.check_result(out_data);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[approx_div64_by_64_core] ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random value whose highest set bit is bit nbits-1; zero for nbits == 0.
  function automatic logic [63:0] rand_of_width(int unsigned nbits);
    logic [63:0] v;
    v = rand64();
    if (nbits == 0) return 64'd0;
    if (nbits < 64) v = v & ((64'd1 << nbits) - 64'd1);
    v[nbits-1] = 1'b1;
    return v;
  endfunction

  // Hold start high across back-to-back beats; drop it only for a gap.
  task automatic send_beat(input logic [63:0] dividend, input logic [63:0] divisor);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= '{dividend: dividend, divisor: divisor};
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random_beat();
    logic [63:0] dividend;
    logic [63:0] divisor;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)       divisor = 64'd0;
    else if (pick < 30) divisor = rand_of_width($urandom_range(1, 32));
    else if (pick < 90) divisor = rand_of_width($urandom_range(33, 64));
    else                divisor = rand64();
    if ($urandom_range(0, 3) == 0) dividend = rand_of_width($urandom_range(0, 64));
    else                           dividend = rand64();
    send_beat(dividend, divisor);
  endtask

  initial begin
    int unsigned n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero divisor, with and without a dividend
    send_beat(64'd0, 64'd0);
    send_beat('1, 64'd0);
    send_beat(64'd12345, 64'd0);
    // divisor that fits in 32 bits
    send_beat(64'd1, 64'd1);
    send_beat('1, 64'd1);
    send_beat(64'd0, 64'd1);
    send_beat('1, 64'h0000_0000_FFFF_FFFF);
    send_beat(64'h0000_0000_FFFF_FFFE, 64'h0000_0000_FFFF_FFFF);
    send_beat('1, 64'h0000_0000_8000_0000);
    // large divisor, every shift extreme
    send_beat('1, 64'h0000_0001_0000_0000);
    send_beat('1, 64'h0000_0001_FFFF_FFFF);
    send_beat('1, 64'h8000_0000_0000_0000);
    send_beat('1, '1);
    send_beat(64'd0, '1);
    send_beat(64'h7FFF_FFFF_FFFF_FFFF, '1);
    send_beat('1, 64'hFFFF_FFFF_0000_0000);
    send_beat(64'h8000_0000_0000_0000, 64'h0000_0002_0000_0001);
    send_beat(64'h0123_4567_89AB_CDEF, 64'h0000_0000_0000_0003);
    send_beat(64'hFEDC_BA98_7654_3210, 64'h0001_0000_0000_0000);
    send_beat(64'd5, 64'h0000_0001_0000_0000);

    for (n = 0; n < RANDOM_BEATS; n++) begin
      // alternate stretches of back-to-back beats with gappy ones
      if (n % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
      send_random_beat();
    end
    start <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatch_count == 0) begin
      $display("[approx_div64_by_64_core] OK");
    end else begin
      $display("[approx_div64_by_64_core] ERROR");
    end
    $finish;
  end

endmodule
